@@ rtl/core/stepper_trapezoid_ramp_generator_unit_macros.svh @@
// Assertion macros for the stepper ramp generator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef STEPPER_TRAPEZOID_RAMP_GENERATOR_UNIT_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define STRG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/strg_pkg.sv @@
// Shared types and constants for the stepper ramp generator.
// No dependencies.
package strg_pkg;

    localparam int ACC_W   = 74;  // product / dividend width
    localparam int DVS_W   = 34;  // divisor width
    localparam int Q_W     = 42;  // quotient width that is used
    localparam int IV_W    = 40;  // interval width
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] ITER_DIV1 = 7'd41;
    localparam logic [CNT_W-1:0] ITER_MUL  = 7'd32;
    localparam logic [CNT_W-1:0] ITER_DIV2 = 7'd74;

    localparam logic [IV_W-1:0] IV_MAX = {IV_W{1'b1}};

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_REL     = 3'd1;
    localparam logic [2:0] OP_ABS     = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_SETPOS  = 3'd4;

    localparam logic [2:0] REG_FIRST_IV = 3'd0;
    localparam logic [2:0] REG_RAMP     = 3'd1;
    localparam logic [2:0] REG_PW       = 3'd2;
    localparam logic [2:0] REG_INV      = 3'd3;

    typedef struct packed {
        logic             start;
        logic             is_div;
        logic [CNT_W-1:0] iters;
    } mdu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mdu_stat_t;

endpackage

@@ rtl/core/strg_mdu.sv @@
// Iterative multiply / divide unit built around one shared adder.
// Depends on strg_pkg.
module strg_mdu
    import strg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mdu_cmd_t         cmd,
    input  logic [ACC_W-1:0] opa,
    input  logic [DVS_W-1:0] opb,
    output mdu_stat_t        stat,
    output logic [ACC_W-1:0] result
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] opr_reg, opr_next;
    logic [31:0]      mier_reg, mier_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [ACC_W-1:0] add_x, add_y;
    logic [ACC_W:0]   sum;
    logic             ge;

    // One adder serves both the trial subtract and the shift-add step.
    always_comb
    begin
        if (div_reg)
        begin
            add_x = {{(ACC_W-DVS_W-1){1'b0}}, rem_reg, acc_reg[ACC_W-1]};
            add_y = ~opr_reg;
        end
        else
        begin
            add_x = {acc_reg[ACC_W-2:0], 1'b0};
            add_y = mier_reg[31] ? opr_reg : '0;
        end
        sum = {1'b0, add_x} + {1'b0, add_y} + {{ACC_W{1'b0}}, div_reg};
        ge  = sum[ACC_W];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        opr_next  = opr_reg;
        mier_next = mier_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            div_next  = cmd.is_div;
            cnt_next  = cmd.iters;
            busy_next = 1'b1;
            rem_next  = '0;
            if (cmd.is_div)
            begin
                acc_next = opa;
                opr_next = {{(ACC_W-DVS_W){1'b0}}, opb};
            end
            else
            begin
                acc_next  = '0;
                opr_next  = opa;
                mier_next = opb[31:0];
            end
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_next = ge ? sum[DVS_W-1:0] : add_x[DVS_W-1:0];
                acc_next = {acc_reg[ACC_W-2:0], ge};
            end
            else
            begin
                acc_next  = sum[ACC_W-1:0];
                mier_next = {mier_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        opr_reg  <= opr_next;
        mier_reg <= mier_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

@@ rtl/core/stepper_trapezoid_ramp_generator_unit.sv @@
// Top level of the stepper trapezoidal ramp generator: tick sequencer and state.
// Depends on strg_pkg, strg_mdu and the assertion macro header.
//
//  channel  | direction | handshake              | content
//  s_axis   | in        | tvalid / tready        | one tick word, opcode in tuser
//  m_axis   | out       | tvalid / tready        | one status word per tick
//  cfg      | in        | cfg_valid / cfg_ready  | register index and data
//
// A tick without a new step interval goes from S_IDLE to S_APPLY, which registers the result.
// A tick that starts a step inside the ramps also passes S_PREP, S_DIV1, S_MUL and S_DIV2: one divide
// (41 iterations), one multiply (32) and one divide (74) in the shared unit.
// No input word is taken while a result waits; reset needs no clearing pass.
`include "stepper_trapezoid_ramp_generator_unit_macros.svh"

module stepper_trapezoid_ramp_generator_unit
    import strg_pkg::*;
#(
    parameter int POSITION_WIDTH = 32,
    parameter int FRACTION_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] step_level, [1] dir_level, [2] running, [34:3] current_position,
    // [58:35] current_interval, [63:59] zero
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV1, S_MUL, S_DIV2, S_APPLY} state_t;

    state_t state_reg, state_next;

    logic [31:0] fi_reg;
    logic [30:0] rs_reg;
    logic [15:0] pw_reg;
    logic        inv_reg;

    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic        active_reg, active_next;
    logic        fwd_reg, fwd_next;
    logic        stop_reg, stop_next;
    logic        open_reg, open_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] stepn_reg, stepn_next;
    logic [31:0] ramp_reg, ramp_next;
    logic [IV_W-1:0] ivl_reg, ivl_next;
    logic [32:0] ticks_reg, ticks_next;
    logic [2:0]  op_reg, op_next;
    logic [31:0] opnd_reg, opnd_next;
    logic        accel_reg, accel_next;
    logic [31:0] fa_reg, fa_next;
    logic [DVS_W-1:0] fc_reg, fc_next;
    logic        tvalid_reg, tvalid_next;
    logic [63:0] tdata_reg, tdata_next;

    mdu_cmd_t         mcmd;
    mdu_stat_t        mstat;
    logic [ACC_W-1:0] mopa, mres;
    logic [DVS_W-1:0] mopb;

    logic in_acc;

    // Tick advance terms
    logic [32:0] t_inc, e_w, p_w;
    logic [IV_W-1:0] pint;
    logic        pend, endmove, open_a, act_a, fire;
    logic [32:0] stepn_inc;

    // Ramp step terms
    logic [32:0] j_w;
    logic [31:0] n3;
    logic        is_acc, is_dec;

    // Command terms
    logic [63:0] pos_z, set_v;
    logic [31:0] cnt_v, mag_v, half_v, ramp_v;
    logic        fwd_v;
    logic [Q_W-1:0]  dq;
    logic [Q_W:0]    dsum;
    logic [IV_W-1:0] ivl_dec;
    logic [IV_W-1:0] iv_int;
    logic [23:0]     iv_sat;

    function automatic logic [IV_W-1:0] raise_iv(input logic [IV_W-1:0] x,
                                                 input logic [15:0] pw);
        logic [IV_W-1:0] fl;
        fl = IV_W'(pw) << FRACTION_BITS;
        return (x < fl) ? fl : x;
    endfunction

    strg_mdu u_mdu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mcmd),
        .opa    (mopa),
        .opb    (mopb),
        .stat   (mstat),
        .result (mres)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !tvalid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg  <= 32'd256000;
            rs_reg  <= 31'd100;
            pw_reg  <= 16'd5;
            inv_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FIRST_IV: fi_reg  <= cfg_data;
                REG_RAMP:     rs_reg  <= cfg_data[30:0];
                REG_PW:       pw_reg  <= cfg_data[15:0];
                REG_INV:      inv_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Advance of the running move for one tick.
    always_comb
    begin
        t_inc     = ticks_reg + 33'd1;
        e_w       = (pw_reg == 16'd0) ? 33'd1 : 33'(pw_reg);
        stepn_inc = 33'(stepn_reg) + 33'd1;
        pend      = active_reg && open_reg && (t_inc >= e_w);
        endmove   = pend && (stop_reg || (stepn_inc >= 33'(total_reg)));
        act_a     = active_reg && !endmove;
        open_a    = pend ? 1'b0 : open_reg;
        pint      = ivl_reg >> FRACTION_BITS;
        p_w       = ({1'b0, pint} < {{(IV_W-32){1'b0}}, e_w}) ? e_w : pint[32:0];
        if (pint > IV_W'(33'h1_FFFF_FFFF))
            p_w = 33'h1_FFFF_FFFF;
        fire      = act_a && !open_a && (t_inc >= p_w);
    end

    // Ramp step selection from the registered state.
    always_comb
    begin
        j_w    = stepn_inc;
        n3     = total_reg - ramp_reg;
        is_acc = j_w < 33'(ramp_reg);
        is_dec = !is_acc && (j_w >= 33'(n3)) && (ramp_reg >= 32'd2);
    end

    // Command terms and interval update from the divide result.
    always_comb
    begin
        pos_z  = 64'(pos_reg);
        set_v  = {{32{opnd_reg[31]}}, opnd_reg};
        cnt_v  = (op_reg == OP_ABS) ? (opnd_reg - pos_z[31:0]) : opnd_reg;
        fwd_v  = !cnt_v[31];
        mag_v  = fwd_v ? cnt_v : (32'd0 - cnt_v);
        half_v = mag_v >> 1;
        ramp_v = (32'(rs_reg) < half_v) ? 32'(rs_reg) : half_v;
        dq     = mres[Q_W-1:0];
        dsum   = {1'b0, {(Q_W-IV_W){1'b0}}, ivl_reg} + {1'b0, dq};
        ivl_dec = (dsum > (Q_W+1)'(IV_MAX)) ? IV_MAX : dsum[IV_W-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        fwd_next    = fwd_reg;
        stop_next   = stop_reg;
        open_next   = open_reg;
        total_next  = total_reg;
        stepn_next  = stepn_reg;
        ramp_next   = ramp_reg;
        ivl_next    = ivl_reg;
        ticks_next  = ticks_reg;
        op_next     = op_reg;
        opnd_next   = opnd_reg;
        accel_next  = accel_reg;
        fa_next     = fa_reg;
        fc_next     = fc_reg;
        tvalid_next = tvalid_reg && !m_axis_tready;
        tdata_next  = tdata_reg;
        mcmd        = '0;
        mopa        = '0;
        mopb        = '0;
        iv_int      = '0;
        iv_sat      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next   = s_axis_tuser;
                    opnd_next = s_axis_tdata;
                    if (active_reg)
                    begin
                        if (pend)
                            pos_next = fwd_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                        active_next = act_a;
                        if (endmove)
                            stop_next = 1'b0;
                        open_next  = fire ? 1'b1 : open_a;
                        stepn_next = fire ? stepn_inc[31:0] : stepn_reg;
                        ticks_next = fire ? 33'd0 : t_inc;
                    end
                    // A new interval is due when a pulse starts that is not the last.
                    if (active_reg && fire && (33'(stepn_inc[31:0]) + 33'd1 < 33'(total_reg)))
                        state_next = S_PREP;
                    else
                        state_next = S_APPLY;
                end
            end

            S_PREP:
            begin
                accel_next = is_acc;
                if (is_acc)
                begin
                    fa_next    = ramp_reg - stepn_reg;
                    fc_next    = DVS_W'(ramp_reg);
                    mcmd       = '{start: 1'b1, is_div: 1'b1, iters: ITER_DIV1};
                    mopa       = {ivl_reg, 1'b0, {(ACC_W-IV_W-1){1'b0}}};
                    mopb       = {stepn_reg, 2'b01};
                    state_next = S_DIV1;
                end
                else if (is_dec)
                begin
                    fa_next    = j_w[31:0] - n3;
                    fc_next    = DVS_W'(ramp_reg - 32'd1);
                    mcmd       = '{start: 1'b1, is_div: 1'b1, iters: ITER_DIV1};
                    mopa       = {ivl_reg, 1'b0, {(ACC_W-IV_W-1){1'b0}}};
                    mopb       = {total_reg - stepn_reg - 32'd2, 2'b11};
                    state_next = S_DIV1;
                end
                else
                begin
                    ivl_next   = raise_iv(ivl_reg, pw_reg);
                    state_next = S_APPLY;
                end
            end

            S_DIV1:
            begin
                if (mstat.done)
                begin
                    mcmd       = '{start: 1'b1, is_div: 1'b0, iters: ITER_MUL};
                    mopa       = {{(ACC_W-Q_W){1'b0}}, mres[Q_W-1:0]};
                    mopb       = {2'b00, fa_reg};
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                if (mstat.done)
                begin
                    mcmd       = '{start: 1'b1, is_div: 1'b1, iters: ITER_DIV2};
                    mopa       = mres;
                    mopb       = fc_reg;
                    state_next = S_DIV2;
                end
            end

            S_DIV2:
            begin
                if (mstat.done)
                begin
                    if (accel_reg)
                        ivl_next = raise_iv(ivl_reg - dq[IV_W-1:0], pw_reg);
                    else
                        ivl_next = raise_iv(ivl_dec, pw_reg);
                    state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                if ((op_reg == OP_REL) || (op_reg == OP_ABS))
                begin
                    if (!active_reg)
                    begin
                        fwd_next = fwd_v;
                        if (mag_v != 32'd0)
                        begin
                            active_next = 1'b1;
                            stop_next   = 1'b0;
                            open_next   = 1'b1;
                            total_next  = mag_v;
                            stepn_next  = '0;
                            ramp_next   = ramp_v;
                            ivl_next    = raise_iv(IV_W'(fi_reg), pw_reg);
                            ticks_next  = '0;
                        end
                    end
                end
                else if (op_reg == OP_STOP)
                begin
                    if (active_reg)
                        stop_next = 1'b1;
                end
                else if (op_reg == OP_SETPOS)
                begin
                    pos_next = set_v[POSITION_WIDTH-1:0];
                end

                iv_int = ivl_next >> FRACTION_BITS;
                iv_sat = (iv_int > IV_W'(24'hFF_FFFF)) ? 24'hFF_FFFF : iv_int[23:0];
                tdata_next = {5'b0, iv_sat, 32'(pos_next), active_next, (!fwd_next) ^ inv_reg,
                              active_next && open_next && (pw_reg != 16'd0)};
                tvalid_next = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            active_reg <= 1'b0;
            fwd_reg    <= 1'b0;
            stop_reg   <= 1'b0;
            open_reg   <= 1'b0;
            total_reg  <= '0;
            stepn_reg  <= '0;
            ramp_reg   <= '0;
            ivl_reg    <= '0;
            ticks_reg  <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            active_reg <= active_next;
            fwd_reg    <= fwd_next;
            stop_reg   <= stop_next;
            open_reg   <= open_next;
            total_reg  <= total_next;
            stepn_reg  <= stepn_next;
            ramp_reg   <= ramp_next;
            ivl_reg    <= ivl_next;
            ticks_reg  <= ticks_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        opnd_reg  <= opnd_next;
        accel_reg <= accel_next;
        fa_reg    <= fa_next;
        fc_reg    <= fc_next;
        tdata_reg <= tdata_next;
    end

    `STRG_ASSERT_NOW(a_ready_no_pending, s_axis_tready, !m_axis_tvalid, "ready while a result waits")
    `STRG_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "ready right after accept")
    `STRG_ASSERT_NOW(a_step_needs_run, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[2], "step without move")
    `STRG_ASSERT_NOW(a_mdu_idle_in_idle, state_reg == S_IDLE, !mstat.busy, "arithmetic unit busy while idle")

endmodule

@@ bench/stepper_ramp_status_checker.sv @@
// Status checker for the stepper trapezoidal ramp generator: it mirrors the
// tick sequencer, predicts one status word per tick word and compares them.
// Depends on strg_pkg for the opcode and register codes.
`timescale 1ns / 100ps

module stepper_ramp_status_checker
    import strg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int FRAC = 8;
    localparam longint unsigned IVL_LIMIT = 64'hFF_FFFF_FFFF;

    // Register copies, at their reset values.
    bit [31:0] first_ivl = 32'd256000;
    bit [30:0] ramp_cfg  = 31'd100;
    bit [15:0] pulse_len = 16'd5;
    bit        dir_inv   = 1'b0;

    // Motion state.
    bit [31:0]       position = '0;
    bit              moving, forward, stop_req, pulse_high;
    longint unsigned move_len, steps_done, ramp_len, ivl, tick_count;

    logic [63:0] status_expected_q[$];

    initial begin
        errors = 0;
        moving = 0; forward = 0; stop_req = 0; pulse_high = 0;
        move_len = 0; steps_done = 0; ramp_len = 0; ivl = 0; tick_count = 0;
    end

    assign pending = status_expected_q.size();

    // Exact floor(t*a/c) without overflowing 64 bits.
    function automatic longint unsigned scaled_quotient(longint unsigned t,
            longint unsigned a, longint unsigned c);
        if (c == 0)
            return 0;
        return (t / c) * a + ((t % c) * a) / c;
    endfunction

    function automatic longint unsigned at_least_pulse(longint unsigned v);
        longint unsigned lo;
        lo = longint'(pulse_len) << FRAC;
        return (v < lo) ? lo : v;
    endfunction

    // Interval for step j of the move: shorten, hold or lengthen.
    function automatic void update_interval(longint unsigned j);
        longint unsigned n3, ci;
        n3 = move_len - ramp_len;
        ci = ivl;
        if (j < ramp_len)
            ci -= scaled_quotient((2 * ci) / (4 * (j - 1) + 1), ramp_len - j + 1, ramp_len);
        else if (j < n3) begin
        end
        else if (ramp_len >= 2 && j < move_len) begin
            ci += scaled_quotient((2 * ci) / (4 * (move_len - j) - 1), j - n3, ramp_len - 1);
            if (ci > IVL_LIMIT)
                ci = IVL_LIMIT;
        end
        ivl = at_least_pulse(ci);
    endfunction

    function automatic void begin_move(bit [31:0] count);
        bit [31:0] mag;
        forward = ~count[31];
        mag = forward ? count : -count;
        if (mag == 0)
            return;
        moving     = 1;
        stop_req   = 0;
        pulse_high = 1;
        move_len   = mag;
        steps_done = 0;
        ramp_len   = (longint'(ramp_cfg) < (mag >> 1)) ? ramp_cfg : (mag >> 1);
        ivl        = at_least_pulse(first_ivl);
        tick_count = 0;
    endfunction

    // One tick: the running move advances first, then the command applies.
    function automatic logic [63:0] tick_status(bit [2:0] op, bit [31:0] arg);
        longint unsigned t, hi_len, gap;
        bit [23:0] ivl_int;
        if (moving) begin
            t = tick_count + 1;
            hi_len = (pulse_len != 0) ? pulse_len : 1;
            if (pulse_high && t >= hi_len) begin
                pulse_high = 0;
                position = forward ? position + 1 : position - 1;
                if (stop_req || steps_done + 1 >= move_len) begin
                    moving = 0;
                    stop_req = 0;
                end
            end
            if (moving && !pulse_high) begin
                gap = ivl >> FRAC;
                if (gap < hi_len)
                    gap = hi_len;
                if (t >= gap) begin
                    steps_done++;
                    t = 0;
                    pulse_high = 1;
                    if (steps_done + 1 < move_len)
                        update_interval(steps_done + 1);
                end
            end
            tick_count = t;
        end

        case (op)
            OP_REL, OP_ABS:
                if (!moving)
                    begin_move(op == OP_ABS ? arg - position : arg);
            OP_STOP:
                if (moving)
                    stop_req = 1;
            OP_SETPOS:
                position = arg;
            default: ;
        endcase

        ivl_int = ((ivl >> FRAC) > 64'hFF_FFFF) ? 24'hFF_FFFF : ivl[FRAC +: 24];
        return {5'd0, ivl_int, position, moving, (~forward) ^ dir_inv,
                moving && pulse_high && pulse_len != 0};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 30)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk) begin
        logic [63:0] want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_expected_q.size() == 0)
                    report_mismatch("unexpected status word", m_axis_tdata, 'x);
                else begin
                    want = status_expected_q.pop_front();
                    if (m_axis_tdata[0] !== want[0])
                        report_mismatch("step_level", m_axis_tdata[0], want[0]);
                    if (m_axis_tdata[1] !== want[1])
                        report_mismatch("dir_level", m_axis_tdata[1], want[1]);
                    if (m_axis_tdata[2] !== want[2])
                        report_mismatch("running", m_axis_tdata[2], want[2]);
                    if (m_axis_tdata[34:3] !== want[34:3])
                        report_mismatch("current_position", m_axis_tdata[34:3], want[34:3]);
                    if (m_axis_tdata[58:35] !== want[58:35])
                        report_mismatch("current_interval", m_axis_tdata[58:35], want[58:35]);
                    if (m_axis_tdata[63:59] !== want[63:59])
                        report_mismatch("padding", m_axis_tdata[63:59], want[63:59]);
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_FIRST_IV: first_ivl = cfg_data;
                    REG_RAMP:     ramp_cfg  = cfg_data[30:0];
                    REG_PW:       pulse_len = cfg_data[15:0];
                    REG_INV:      dir_inv   = cfg_data[0];
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready)
                status_expected_q.push_back(tick_status(s_axis_tuser, s_axis_tdata));
        end
    end

endmodule

@@ bench/stepper_trapezoid_ramp_generator_unit_tb.sv @@
// Top of the ramp generator bench: clock, reset, tick and register stimulus,
// output stalls and the verdict. Depends on strg_pkg, the block and
// stepper_ramp_status_checker.
`timescale 1ns / 100ps

module stepper_trapezoid_ramp_generator_unit_tb;
    import strg_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = OP_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_FIRST_IV;
    logic [31:0] cfg_data = '0;

    int errors, pending;
    int burst_left = 0;
    int idle_cycles = 0;

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    stepper_trapezoid_ramp_generator_unit dut (.*);

    stepper_ramp_status_checker checker_i (.*);

    // Output side: stall style rotates through always ready, half random and mostly
    // stalled, plus one long hold-off while the tick stream keeps coming.
    int rx_cycle = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle == 4000)
            hold_left = 1500;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            case ((rx_cycle >> 8) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    // Stall watchdog: any accepted word resets it.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_tick(logic [2:0] op, logic [31:0] val);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_tick(OP_TICK, $urandom);
    endtask

    // Registers change only once every status word has come back.
    task automatic load_registers(logic [31:0] first_iv, logic [30:0] ramp,
            logic [15:0] pw, logic inv);
        logic [31:0] vals[4];
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        vals = '{first_iv, {1'b0, ramp}, {16'd0, pw}, {31'd0, inv}};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68)
            send_tick(OP_TICK, $urandom);
        else if (r < 80)
            send_tick(OP_REL, ($urandom_range(0, 7) == 0) ? $urandom
                : ($urandom_range(0, 1) ? $urandom_range(1, 24) : -$urandom_range(1, 24)));
        else if (r < 85)
            send_tick(OP_ABS, ($urandom_range(0, 3) == 0) ? $urandom
                : $urandom_range(0, 40) - 20);
        else if (r < 90)
            send_tick(OP_STOP, $urandom);
        else if (r < 95)
            send_tick(OP_SETPOS, ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 20)));
        else
            send_tick($urandom_range(5, 7), $urandom);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset register values.
        send_tick(OP_STOP, 0);                 // stop while idle
        send_tick(OP_SETPOS, 32'h7FFF_FFFF);
        send_tick(OP_REL, 1);                  // position wraps to the minimum
        send_ticks(6);
        send_tick(OP_SETPOS, 32'h8000_0000);
        send_tick(OP_REL, -1);
        send_tick(OP_REL, 5);                  // ignored while running
        send_ticks(6);
        send_tick(OP_REL, 0);                  // zero move only sets forward
        send_tick(OP_ABS, 32'h8000_0000);      // one step forward
        send_tick(5, 32'hFFFF_FFFF);
        send_tick(6, 0);
        send_tick(7, 32'h5555_AAAA);
        send_tick(OP_REL, 32'h8000_0000);      // ignored while the one-step move runs
        send_ticks(2);
        send_tick(OP_SETPOS, 0);               // set position while idle
        send_ticks(4);
        send_tick(OP_STOP, 0);                 // stop while idle

        // Zero pulse width, a ramp length of one (no deceleration step), inverted pin.
        load_registers(32'd768, 31'd1, 16'd0, 1'b1);
        send_tick(OP_REL, 3);
        send_ticks(12);
        send_tick(OP_ABS, 32'hFFFF_FFF0);
        send_ticks(40);
        send_tick(OP_STOP, 0);
        send_ticks(10);

        // Extreme register values.
        load_registers(32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
        send_tick(OP_REL, 9);
        send_ticks(30);
        send_tick(OP_STOP, 0);
        load_registers(32'd256, 31'd0, 16'd1, 1'b1);
        send_tick(OP_REL, -10);
        send_ticks(40);

        // Random phases, small intervals so that ramps run to their end.
        for (int ph = 0; ph < 6; ph++)
        begin
            load_registers(256 * $urandom_range(1, 30) + $urandom_range(0, 255),
                $urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 1));
            repeat (220) random_word();
            send_tick(OP_STOP, 0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ stepper_trapezoid_ramp_generator_unit.f @@
+incdir+rtl/core
rtl/core/strg_pkg.sv
rtl/core/strg_mdu.sv
rtl/core/stepper_trapezoid_ramp_generator_unit.sv
bench/stepper_ramp_status_checker.sv
bench/stepper_trapezoid_ramp_generator_unit_tb.sv
